>>> src/mhtq_pkg.sv
// Shared widths, defaults and result codes for the min-heap timer queue.
package mhtq_pkg;

	localparam int unsigned HEAP_DEPTH_DEF = 128;
	localparam int unsigned TIME_W         = 32;
	localparam int unsigned DELAY_W        = 16;
	localparam int unsigned PENDING_W      = 8;

	typedef enum logic [0:0] {
		REQ_TICK  = 1'b0,
		REQ_START = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_STARTED = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_EXP  = 2'd2,
		ST_EXPIRED = 2'd3
	} status_t;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

endpackage

>>> src/min_heap_timer_queue.sv
// Top level: tick counter, heap sequencer and result register over one heap RAM.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------
//  in      | in_valid/in_ready  | req_type, delay
//  out     | out_valid/out_ready| status, expire_time, pending
//
// One request at a time, in this order of work: a full start or a tick on an empty heap
// goes straight to the output word; a tick with nothing due reads the root and compares it;
// a start climbs the heap level by level, one parent read and compare per level; a tick
// with expiry pops the root, and unless it was the only entry moves the last one down.
// in_ready returns the cycle after the load. The single RAM read port forces the reads apart.
// Reset clears the count and the time; heap entries need no clearing.
// A word waiting on out_ready holds the sequencer in S_OUT once the next request is done.
module min_heap_timer_queue #(
	parameter int unsigned HEAP_DEPTH = mhtq_pkg::HEAP_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic [mhtq_pkg::DELAY_W-1:0]      delay,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [mhtq_pkg::TIME_W-1:0]       expire_time,
	output logic [mhtq_pkg::PENDING_W-1:0]    pending
);

	import mhtq_pkg::*;

	localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int unsigned PW = AW + 1;
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_TOP_CMP,
		S_LAST_RD,
		S_DN_RD1,
		S_DN_RD2,
		S_DN_CMP,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [TIME_W-1:0] now_q;
	logic [AW-1:0]     pos_q;
	logic [TIME_W-1:0] v_q;
	logic [TIME_W-1:0] left_q;
	logic              has_r_q;
	status_t           res_status_q;
	logic [TIME_W-1:0] res_exp_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [TIME_W-1:0] expire_q;
	logic [PENDING_W-1:0] pending_q;

	logic              fire;
	logic [TIME_W:0]   start_sum;
	logic [TIME_W:0]   tick_sum;
	logic [TIME_W-1:0] start_exp;
	logic [TIME_W-1:0] tick_now;
	logic [AW-1:0]     pos_m1;
	logic [AW-1:0]     up_pos;
	logic [PW-1:0]     child_l;
	logic [PW-1:0]     child_r;
	logic [PW-1:0]     n_ext;
	logic              right_wins;
	logic [TIME_W-1:0] min_val;
	logic [AW-1:0]     min_pos;
	logic              full;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [TIME_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [TIME_W-1:0] rd_data;

	mhtq_ram #(
		.WIDTH (TIME_W),
		.DEPTH (HEAP_DEPTH)
	) u_heap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign fire        = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign expire_time = expire_q;
	assign pending     = pending_q;

	assign full      = (cnt_q >= CW'(HEAP_DEPTH));
	assign start_sum = {1'b0, now_q} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
	assign start_exp = start_sum[TIME_W] ? TIME_MAX : start_sum[TIME_W-1:0];
	assign tick_sum  = {1'b0, now_q} + {{TIME_W{1'b0}}, 1'b1};
	assign tick_now  = tick_sum[TIME_W] ? TIME_MAX : tick_sum[TIME_W-1:0];

	assign pos_m1  = pos_q - AW'(1);
	assign up_pos  = pos_m1 >> 1;
	assign child_l = {pos_q, 1'b1};
	assign child_r = {pos_q, 1'b0} + PW'(2);
	assign n_ext   = PW'(cnt_q);

	// rd_data here is the right child when one exists; left was read before it and held in left_q
	assign right_wins = has_r_q && (rd_data < left_q);
	assign min_val    = right_wins ? rd_data : left_q;
	assign min_pos    = right_wins ? child_r[AW-1:0] : child_l[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = v_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en   = fire && (req_t'(req_type) == REQ_TICK);
				rd_addr = '0;
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = up_pos;
				end
			end
			S_UP_CMP: begin
				wr_en   = 1'b1;
				wr_data = (rd_data <= v_q) ? v_q : rd_data;
			end
			S_TOP_CMP: begin
				rd_en   = 1'b1;
				rd_addr = AW'(cnt_q - CW'(1));
			end
			S_DN_RD1: begin
				if (child_l >= n_ext) begin
					wr_en = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = child_l[AW-1:0];
				end
			end
			S_DN_RD2: begin
				rd_en   = (child_r < n_ext);
				rd_addr = child_r[AW-1:0];
			end
			S_DN_CMP: begin
				wr_en   = 1'b1;
				wr_data = (v_q <= min_val) ? v_q : min_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			now_q        <= '0;
			out_valid_q  <= 1'b0;
			pos_q        <= '0;
			v_q          <= '0;
			left_q       <= '0;
			has_r_q      <= 1'b0;
			res_status_q <= ST_NO_EXP;
			res_exp_q    <= '0;
			status_q     <= ST_NO_EXP;
			expire_q     <= '0;
			pending_q    <= '0;
		end else begin
			// S_OUT reloads the word itself when it hands one over
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						if (req_t'(req_type) == REQ_START) begin
							if (full) begin
								res_status_q <= ST_FULL;
								res_exp_q    <= '0;
								state_q      <= S_OUT;
							end else begin
								pos_q        <= AW'(cnt_q);
								cnt_q        <= cnt_q + CW'(1);
								v_q          <= start_exp;
								res_status_q <= ST_STARTED;
								res_exp_q    <= start_exp;
								state_q      <= S_UP_RD;
							end
						end else begin
							now_q        <= tick_now;
							res_status_q <= ST_NO_EXP;
							res_exp_q    <= '0;
							state_q      <= (cnt_q == '0) ? S_OUT : S_TOP_CMP;
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_OUT : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (rd_data <= v_q) begin
						state_q <= S_OUT;
					end else begin
						pos_q   <= up_pos;
						state_q <= S_UP_RD;
					end
				end
				S_TOP_CMP: begin
					// now_q already holds the advanced time
					if (rd_data <= now_q) begin
						res_status_q <= ST_EXPIRED;
						res_exp_q    <= rd_data;
						cnt_q        <= cnt_q - CW'(1);
						state_q      <= (cnt_q == CW'(1)) ? S_OUT : S_LAST_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_LAST_RD: begin
					v_q     <= rd_data;
					pos_q   <= '0;
					state_q <= S_DN_RD1;
				end
				S_DN_RD1: begin
					state_q <= (child_l >= n_ext) ? S_OUT : S_DN_RD2;
				end
				S_DN_RD2: begin
					left_q  <= rd_data;
					has_r_q <= (child_r < n_ext);
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (v_q <= min_val) begin
						state_q <= S_OUT;
					end else begin
						pos_q   <= min_pos;
						state_q <= S_DN_RD1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						expire_q    <= res_exp_q;
						pending_q   <= PENDING_W'(cnt_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/mhtq_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module mhtq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
